>>> rtl/core/rgbyc_pkg.sv
// Shared types, register codes and Q16 contribution tables for the RGB to YCbCr converter.
package rgbyc_pkg;

    localparam int PIX_W      = 8;
    localparam int LUT_W      = 27;
    localparam int Q16_SHIFT  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLORIMETRY   = 1'b0,
        REG_SAMPLING_MODE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        COL_BT709  = 2'd0,
        COL_BT2020 = 2'd1,
        COL_BT2100 = 2'd2,
        COL_DCIP3  = 2'd3
    } t_colorimetry;

    typedef enum logic {
        MODE_422 = 1'b0,
        MODE_444 = 1'b1
    } t_sampling;

    typedef logic signed [LUT_W-1:0] t_q16;
    typedef t_q16 [255:0] t_lut;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic valid;
        logic pair;
    } t_stage_ctl;

    typedef struct packed {
        t_q16 y;
        t_q16 cb;
        t_q16 cr;
    } t_terms;

    // Luma weights in units of 1/10000
    localparam longint KR709  = 2126;
    localparam longint KB709  = 722;
    localparam longint KG709  = 10000 - KR709 - KB709;
    localparam longint KR2020 = 2627;
    localparam longint KB2020 = 593;
    localparam longint KG2020 = 10000 - KR2020 - KB2020;

    localparam longint SC_Y = 876 * 65536;
    localparam longint SC_C = 448 * 65536;

    localparam longint DEN_Y      = 10000 * 255;
    localparam longint DEN_HALF   = 2 * 255;
    localparam longint DEN_CB709  = 2 * (10000 - KB709) * 255;
    localparam longint DEN_CB2020 = 2 * (10000 - KB2020) * 255;
    localparam longint DEN_CR709  = 2 * (10000 - KR709) * 255;
    localparam longint DEN_CR2020 = 2 * (10000 - KR2020) * 255;

    typedef enum logic [3:0] {
        ID_Y_R709,
        ID_Y_G709,
        ID_Y_B709,
        ID_Y_R2020,
        ID_Y_G2020,
        ID_Y_B2020,
        ID_CB_R709,
        ID_CB_G709,
        ID_CB_R2020,
        ID_CB_G2020,
        ID_HALF,
        ID_CR_G709,
        ID_CR_B709,
        ID_CR_G2020,
        ID_CR_B2020
    } t_lut_id;

    // Round half up for positive and negative terms alike (ties toward plus infinity)
    function automatic t_q16 lut_entry(t_lut_id id, longint v);
        longint e;
        unique case (id)
            ID_Y_R709:   e = (2 * KR709 * SC_Y * v + DEN_Y) / (2 * DEN_Y);
            ID_Y_G709:   e = (2 * KG709 * SC_Y * v + DEN_Y) / (2 * DEN_Y);
            ID_Y_B709:   e = (2 * KB709 * SC_Y * v + DEN_Y) / (2 * DEN_Y);
            ID_Y_R2020:  e = (2 * KR2020 * SC_Y * v + DEN_Y) / (2 * DEN_Y);
            ID_Y_G2020:  e = (2 * KG2020 * SC_Y * v + DEN_Y) / (2 * DEN_Y);
            ID_Y_B2020:  e = (2 * KB2020 * SC_Y * v + DEN_Y) / (2 * DEN_Y);
            ID_CB_R709:  e = -((2 * KR709 * SC_C * v + DEN_CB709 - 1) / (2 * DEN_CB709));
            ID_CB_G709:  e = -((2 * KG709 * SC_C * v + DEN_CB709 - 1) / (2 * DEN_CB709));
            ID_CB_R2020: e = -((2 * KR2020 * SC_C * v + DEN_CB2020 - 1) / (2 * DEN_CB2020));
            ID_CB_G2020: e = -((2 * KG2020 * SC_C * v + DEN_CB2020 - 1) / (2 * DEN_CB2020));
            ID_HALF:     e = (2 * SC_C * v + DEN_HALF) / (2 * DEN_HALF);
            ID_CR_G709:  e = -((2 * KG709 * SC_C * v + DEN_CR709 - 1) / (2 * DEN_CR709));
            ID_CR_B709:  e = -((2 * KB709 * SC_C * v + DEN_CR709 - 1) / (2 * DEN_CR709));
            ID_CR_G2020: e = -((2 * KG2020 * SC_C * v + DEN_CR2020 - 1) / (2 * DEN_CR2020));
            ID_CR_B2020: e = -((2 * KB2020 * SC_C * v + DEN_CR2020 - 1) / (2 * DEN_CR2020));
            default:     e = 0;
        endcase
        return LUT_W'(e);
    endfunction

    function automatic t_lut build_lut(t_lut_id id);
        t_lut lut;
        for (int v = 0; v < 256; v++) begin
            lut[v] = lut_entry(id, longint'(v));
        end
        return lut;
    endfunction

    localparam t_lut LUT_Y_R709   = build_lut(ID_Y_R709);
    localparam t_lut LUT_Y_G709   = build_lut(ID_Y_G709);
    localparam t_lut LUT_Y_B709   = build_lut(ID_Y_B709);
    localparam t_lut LUT_Y_R2020  = build_lut(ID_Y_R2020);
    localparam t_lut LUT_Y_G2020  = build_lut(ID_Y_G2020);
    localparam t_lut LUT_Y_B2020  = build_lut(ID_Y_B2020);
    localparam t_lut LUT_CB_R709  = build_lut(ID_CB_R709);
    localparam t_lut LUT_CB_G709  = build_lut(ID_CB_G709);
    localparam t_lut LUT_CB_R2020 = build_lut(ID_CB_R2020);
    localparam t_lut LUT_CB_G2020 = build_lut(ID_CB_G2020);
    localparam t_lut LUT_HALF     = build_lut(ID_HALF);
    localparam t_lut LUT_CR_G709  = build_lut(ID_CR_G709);
    localparam t_lut LUT_CR_B709  = build_lut(ID_CR_B709);
    localparam t_lut LUT_CR_G2020 = build_lut(ID_CR_G2020);
    localparam t_lut LUT_CR_B2020 = build_lut(ID_CR_B2020);

endpackage

>>> rtl/core/rgbyc_input_stage.sv
// Configuration registers, 4:2:2 pair assembly and the input register.
module rgbyc_input_stage import rgbyc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_pixel                i_pixel,
    input  logic                  i_advance,
    output t_colorimetry          o_colorimetry,
    output t_stage_ctl            o_ctl,
    output t_pixel                o_first,
    output t_pixel                o_second
);

    t_colorimetry r_colorimetry, n_colorimetry;
    t_sampling    r_mode, n_mode;
    logic         r_phase, n_phase;
    t_stage_ctl   r_ctl, n_ctl;
    t_pixel       r_held, r_first, r_second;

    logic accept;
    logic single;
    logic load;
    logic hold;

    always_comb begin
        o_ready = !r_ctl.valid || i_advance;
        accept  = i_valid && o_ready;
        single  = (r_mode == MODE_444);
        load    = accept && (single || r_phase);
        hold    = accept && !single && !r_phase;

        n_colorimetry = r_colorimetry;
        n_mode        = r_mode;
        n_phase       = r_phase;
        if (accept && !single) begin
            n_phase = !r_phase;
        end
        // a mode write drops any half-formed pair
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_COLORIMETRY: begin
                    n_colorimetry = t_colorimetry'(i_cfg_data);
                end
                REG_SAMPLING_MODE: begin
                    n_mode  = t_sampling'(i_cfg_data[0]);
                    n_phase = 1'b0;
                end
            endcase
        end

        n_ctl = r_ctl;
        if (load) begin
            n_ctl.valid = 1'b1;
            n_ctl.pair  = !single;
        end else if (i_advance) begin
            n_ctl.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colorimetry <= COL_BT709;
            r_mode        <= MODE_422;
            r_phase       <= 1'b0;
            r_ctl         <= '0;
        end else begin
            r_colorimetry <= n_colorimetry;
            r_mode        <= n_mode;
            r_phase       <= n_phase;
            r_ctl         <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold) begin
            r_held <= i_pixel;
        end
        if (load) begin
            r_first  <= single ? i_pixel : r_held;
            r_second <= i_pixel;
        end
    end

    assign o_colorimetry = r_colorimetry;
    assign o_ctl         = r_ctl;
    assign o_first       = r_first;
    assign o_second      = r_second;

endmodule

>>> rtl/core/rgbyc_pixel_terms.sv
// Table lookup and per-pixel sum of Q16 luma and chroma contributions.
module rgbyc_pixel_terms import rgbyc_pkg::*; (
    input  t_colorimetry i_colorimetry,
    input  t_pixel       i_pixel,
    output t_terms       o_terms
);

    logic wide;
    t_q16 y_r, y_g, y_b;
    t_q16 cb_r, cb_g, cb_b;
    t_q16 cr_r, cr_g, cr_b;

    always_comb begin
        // BT.2100 shares the BT.2020 weights, DCI-P3 those of BT.709
        wide = (i_colorimetry == COL_BT2020) || (i_colorimetry == COL_BT2100);

        y_r  = wide ? LUT_Y_R2020[i_pixel.red]    : LUT_Y_R709[i_pixel.red];
        y_g  = wide ? LUT_Y_G2020[i_pixel.green]  : LUT_Y_G709[i_pixel.green];
        y_b  = wide ? LUT_Y_B2020[i_pixel.blue]   : LUT_Y_B709[i_pixel.blue];
        cb_r = wide ? LUT_CB_R2020[i_pixel.red]   : LUT_CB_R709[i_pixel.red];
        cb_g = wide ? LUT_CB_G2020[i_pixel.green] : LUT_CB_G709[i_pixel.green];
        cb_b = LUT_HALF[i_pixel.blue];
        cr_r = LUT_HALF[i_pixel.red];
        cr_g = wide ? LUT_CR_G2020[i_pixel.green] : LUT_CR_G709[i_pixel.green];
        cr_b = wide ? LUT_CR_B2020[i_pixel.blue]  : LUT_CR_B709[i_pixel.blue];

        o_terms.y  = y_r + y_g + y_b;
        o_terms.cb = cb_r + cb_g + cb_b;
        o_terms.cr = cr_r + cr_g + cr_b;
    end

endmodule

>>> rtl/core/rgbyc_output_stage.sv
// Pair averaging, rounding, offset and clamp, and the result register.
module rgbyc_output_stage import rgbyc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stage_ctl       i_ctl,
    input  t_terms           i_first,
    input  t_terms           i_second,
    input  logic             i_ready,
    output logic             o_advance,
    output logic             o_valid,
    output logic [PIX_W-1:0] o_luma_first,
    output logic [PIX_W-1:0] o_luma_second,
    output logic [PIX_W-1:0] o_chroma_blue,
    output logic [PIX_W-1:0] o_chroma_red
);

    localparam t_q16 ROUND_HALF = t_q16'(32768);
    localparam logic signed [11:0] Y_OFF  = 12'sd64;
    localparam logic signed [11:0] C_OFF  = 12'sd512;
    localparam logic signed [11:0] LO_LIM = 12'sd64;
    localparam logic signed [11:0] Y_HI   = 12'sd940;
    localparam logic signed [11:0] C_HI   = 12'sd960;

    function automatic logic [PIX_W-1:0] finish(t_q16 x, logic signed [11:0] off,
                                                logic signed [11:0] hi);
        t_q16              rnd;
        logic signed [11:0] v;
        rnd = (x + ROUND_HALF) >>> Q16_SHIFT;
        v   = $signed(rnd[11:0]) + off;
        if (v < LO_LIM) v = LO_LIM;
        if (v > hi)     v = hi;
        return v[9:2];
    endfunction

    // truncate toward zero
    function automatic t_q16 half_trunc(t_q16 s);
        return s[LUT_W-1] ? ((s + t_q16'(1)) >>> 1) : (s >>> 1);
    endfunction

    logic             r_valid;
    logic [PIX_W-1:0] r_luma_first, r_luma_second, r_chroma_blue, r_chroma_red;
    logic [PIX_W-1:0] n_luma_first, n_luma_second, n_chroma_blue, n_chroma_red;
    t_q16             cb_sum, cr_sum;

    always_comb begin
        o_advance = !r_valid || i_ready;
        // a single pixel is doubled so that halving returns it unchanged
        cb_sum = i_first.cb + (i_ctl.pair ? i_second.cb : i_first.cb);
        cr_sum = i_first.cr + (i_ctl.pair ? i_second.cr : i_first.cr);

        n_luma_first  = finish(i_first.y, Y_OFF, Y_HI);
        n_luma_second = i_ctl.pair ? finish(i_second.y, Y_OFF, Y_HI) : '0;
        n_chroma_blue = finish(half_trunc(cb_sum), C_OFF, C_HI);
        n_chroma_red  = finish(half_trunc(cr_sum), C_OFF, C_HI);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_ctl.valid) begin
            r_luma_first  <= n_luma_first;
            r_luma_second <= n_luma_second;
            r_chroma_blue <= n_chroma_blue;
            r_chroma_red  <= n_chroma_red;
        end
    end

    assign o_valid       = r_valid;
    assign o_luma_first  = r_luma_first;
    assign o_luma_second = r_luma_second;
    assign o_chroma_blue = r_chroma_blue;
    assign o_chroma_red  = r_chroma_red;

endmodule

>>> rtl/core/rgb_to_ycbcr_converter.sv
// Top level of the RGB to studio-range YCbCr converter.
//
// Input channel: one 8-bit RGB pixel per beat on i_valid / o_ready.
// Output channel: one result beat on o_valid / i_ready carrying luma_first,
// luma_second, chroma_blue and chroma_red, each the 8 MSBs of a clamped
// 10-bit studio-range value.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 colorimetry, 1 sampling mode) at the clock edge; write only while idle.
// In 4:4:4 mode every pixel gives a result with luma_second zero. In 4:2:2
// mode the first pixel of a pair is held and the second gives both lumas and
// pair-averaged chroma; a sampling-mode write drops a half-formed pair.
// Throughput: one pixel per clock while the receiver takes results, set by the
// single lookup-and-sum pass between the input register and the result register.
// The beat completing a result is captured in the input register; its result is
// then registered in the result register and shown there.
// Reset (i_rst_n low, synchronous) empties both registers, selects BT.709 and
// 4:2:2, and expects the first pixel of a pair.
// When the receiver stalls, the result register holds its beat and the input
// register keeps accepting until it too is full; o_ready then falls.
module rgb_to_ycbcr_converter import rgbyc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIX_W-1:0]      i_red,
    input  logic [PIX_W-1:0]      i_green,
    input  logic [PIX_W-1:0]      i_blue,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIX_W-1:0]      o_luma_first,
    output logic [PIX_W-1:0]      o_luma_second,
    output logic [PIX_W-1:0]      o_chroma_blue,
    output logic [PIX_W-1:0]      o_chroma_red
);

    t_pixel       in_pixel;
    t_pixel       first_pixel, second_pixel;
    t_colorimetry colorimetry;
    t_stage_ctl   stage_ctl;
    t_terms       first_terms, second_terms;
    logic         advance;

    assign in_pixel = {i_red, i_green, i_blue};

    // pair assembly and input register
    rgbyc_input_stage u_input (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (in_pixel),
        .i_advance     (advance),
        .o_colorimetry (colorimetry),
        .o_ctl         (stage_ctl),
        .o_first       (first_pixel),
        .o_second      (second_pixel)
    );

    // one lookup unit per pixel of the pair; the second is unused in 4:4:4
    rgbyc_pixel_terms u_terms_first (
        .i_colorimetry (colorimetry),
        .i_pixel       (first_pixel),
        .o_terms       (first_terms)
    );

    rgbyc_pixel_terms u_terms_second (
        .i_colorimetry (colorimetry),
        .i_pixel       (second_pixel),
        .o_terms       (second_terms)
    );

    // averaging, rounding, clamp and result register
    rgbyc_output_stage u_output (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (stage_ctl),
        .i_first       (first_terms),
        .i_second      (second_terms),
        .i_ready       (i_ready),
        .o_advance     (advance),
        .o_valid       (o_valid),
        .o_luma_first  (o_luma_first),
        .o_luma_second (o_luma_second),
        .o_chroma_blue (o_chroma_blue),
        .o_chroma_red  (o_chroma_red)
    );

endmodule

>>> rtl/core/rgbyc_checker.sv
// Port-level checks for the converter, bound to the top level.
module rgbyc_checker import rgbyc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [PIX_W-1:0]      o_luma_first,
    input logic [PIX_W-1:0]      o_luma_second,
    input logic [PIX_W-1:0]      o_chroma_blue,
    input logic [PIX_W-1:0]      o_chroma_red
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_luma_first)
            && $stable(o_luma_second) && $stable(o_chroma_blue) && $stable(o_chroma_red))
        else $error("result beat changed while stalled");

    // an empty result register must never block the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input not ready while output register empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    // studio range after clamp: luma 16..235, chroma 16..240, second luma zero or in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_luma_first >= 8'd16 && o_luma_first <= 8'd235
            && o_chroma_blue >= 8'd16 && o_chroma_blue <= 8'd240
            && o_chroma_red >= 8'd16 && o_chroma_red <= 8'd240
            && (o_luma_second == 8'd0
                || (o_luma_second >= 8'd16 && o_luma_second <= 8'd235)))
        else $error("result outside studio range");

endmodule

bind rgb_to_ycbcr_converter rgbyc_checker u_checker (.*);

>>> test/rgb_to_ycbcr_converter_test.sv
// Self-checking testbench for the RGB to studio-range YCbCr converter.
`timescale 1ns / 100ps

module rgb_to_ycbcr_converter_test;
    import rgbyc_pkg::*;

    // Studio-range limits and offsets on the 10-bit scale
    localparam longint LUMA_OFS   = 64;
    localparam longint CHROMA_OFS = 512;
    localparam longint CODE_MIN   = 64;
    localparam longint LUMA_MAX   = 940;
    localparam longint CHROMA_MAX = 960;
    localparam longint HALF_LSB   = 32768;

    // Quiet cycles before a register write: covers the path through the input
    // and result registers with a wide margin.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_PHASES   = 12;

    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
    } t_ycc;

    // Unrounded Q16 sums for one pixel
    typedef struct {
        longint y;
        longint cb;
        longint cr;
    } t_q16_sums;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic             px_valid = 1'b0;
    logic             px_ready;
    logic [PIX_W-1:0] px_red   = '0;
    logic [PIX_W-1:0] px_green = '0;
    logic [PIX_W-1:0] px_blue  = '0;

    logic             ycc_valid;
    logic             ycc_ready = 1'b0;
    logic [PIX_W-1:0] ycc_luma_first;
    logic [PIX_W-1:0] ycc_luma_second;
    logic [PIX_W-1:0] ycc_chroma_blue;
    logic [PIX_W-1:0] ycc_chroma_red;

    // Stimulus and expected-result stores
    t_pixel pixel_q[$];
    t_ycc   ycc_q[$];

    // Shadow of the converter's configuration and pairing state
    t_colorimetry col_m     = COL_BT709;
    t_sampling    mode_m    = MODE_422;
    bit           pair_open = 1'b0;
    t_pixel       held_px   = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int pixels_in   = 0;
    int beats_out   = 0;
    int mismatches  = 0;
    int cycle_cnt   = 0;

    rgb_to_ycbcr_converter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (px_valid),
        .o_ready       (px_ready),
        .i_red         (px_red),
        .i_green       (px_green),
        .i_blue        (px_blue),
        .o_valid       (ycc_valid),
        .i_ready       (ycc_ready),
        .o_luma_first  (ycc_luma_first),
        .o_luma_second (ycc_luma_second),
        .o_chroma_blue (ycc_chroma_blue),
        .o_chroma_red  (ycc_chroma_red)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // One rounded Q16 weight: sign * num/den * v/255 * scale * 65536, ties upward
    function automatic longint q16_part(longint num, longint den, longint scale,
                                        longint v, bit negate);
        longint n;
        longint d;
        n = num * v * scale * 65536;
        d = den * 255;
        if (negate) begin
            return -((2 * n + d - 1) / (2 * d));
        end
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic t_q16_sums pixel_q16(t_pixel px, t_colorimetry col);
        longint    kr;
        longint    kb;
        longint    kg;
        t_q16_sums s;
        // BT.2100 shares the BT.2020 weights, DCI-P3 the BT.709 ones
        if (col == COL_BT2020 || col == COL_BT2100) begin
            kr = 2627;
            kb = 593;
        end else begin
            kr = 2126;
            kb = 722;
        end
        kg = 10000 - kr - kb;
        s.y  = q16_part(kr, 10000, 876, px.red, 1'b0)
             + q16_part(kg, 10000, 876, px.green, 1'b0)
             + q16_part(kb, 10000, 876, px.blue, 1'b0);
        s.cb = q16_part(kr, 2 * (10000 - kb), 448, px.red, 1'b1)
             + q16_part(kg, 2 * (10000 - kb), 448, px.green, 1'b1)
             + q16_part(1, 2, 448, px.blue, 1'b0);
        s.cr = q16_part(1, 2, 448, px.red, 1'b0)
             + q16_part(kg, 2 * (10000 - kr), 448, px.green, 1'b1)
             + q16_part(kb, 2 * (10000 - kr), 448, px.blue, 1'b1);
        return s;
    endfunction

    // Round off Q16 (floor shift), offset, clamp to studio range, keep the 8 MSBs
    function automatic logic [PIX_W-1:0] studio8(longint q, longint ofs, longint hi);
        longint v;
        v = ((q + HALF_LSB) >>> Q16_SHIFT) + ofs;
        if (v < CODE_MIN) v = CODE_MIN;
        if (v > hi) v = hi;
        return v[9:2];
    endfunction

    // Advance the shadow state by one accepted pixel and queue what it yields
    task automatic convert_pixel(t_pixel px);
        t_q16_sums s0;
        t_q16_sums s1;
        t_ycc      res;
        if (mode_m == MODE_444) begin
            s1 = pixel_q16(px, col_m);
            res.luma_first  = studio8(s1.y, LUMA_OFS, LUMA_MAX);
            res.luma_second = '0;
            res.chroma_blue = studio8(s1.cb, CHROMA_OFS, CHROMA_MAX);
            res.chroma_red  = studio8(s1.cr, CHROMA_OFS, CHROMA_MAX);
            ycc_q.push_back(res);
        end else if (!pair_open) begin
            held_px   = px;
            pair_open = 1'b1;
        end else begin
            // Both pixels use the colorimetry in force when the pair completes
            s0 = pixel_q16(held_px, col_m);
            s1 = pixel_q16(px, col_m);
            pair_open = 1'b0;
            res.luma_first  = studio8(s0.y, LUMA_OFS, LUMA_MAX);
            res.luma_second = studio8(s1.y, LUMA_OFS, LUMA_MAX);
            // Signed division truncates toward zero before rounding
            res.chroma_blue = studio8((s0.cb + s1.cb) / 2, CHROMA_OFS, CHROMA_MAX);
            res.chroma_red  = studio8((s0.cr + s1.cr) / 2, CHROMA_OFS, CHROMA_MAX);
            ycc_q.push_back(res);
        end
    endtask

    // Write one register; the converter is idle whenever this is called
    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_COLORIMETRY) begin
            col_m = t_colorimetry'(data);
        end else begin
            // Only the low bit selects the mode; any write drops a half pair
            mode_m    = t_sampling'(data[0]);
            pair_open = 1'b0;
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                               logic [PIX_W-1:0] b);
        t_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pixel_q.push_back(px);
    endtask

    // Mostly uniform colour, with a share of saturated and near-limit channels
    function automatic logic [PIX_W-1:0] random_channel(int flavour);
        if (flavour < 7) return PIX_W'($urandom_range(255));
        if (flavour < 9) return $urandom_range(1) ? 8'hFF : 8'h00;
        return $urandom_range(1) ? PIX_W'($urandom_range(255, 252))
                                 : PIX_W'($urandom_range(3));
    endfunction

    // Wait for every pixel to be taken and every result to arrive, then settle
    task automatic drain;
        while (pixel_q.size() != 0 || px_valid || ycc_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sender: predict on each accepted beat, then present the next pixel or idle
    always @(posedge i_clk) begin
        if (!rst_n) begin
            px_valid <= 1'b0;
        end else begin
            if (px_valid && px_ready) begin
                convert_pixel('{red: px_red, green: px_green, blue: px_blue});
                pixels_in++;
            end
            // Hold the beat while it waits for the converter
            if (!(px_valid && !px_ready)) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    t_pixel nxt;
                    nxt = pixel_q.pop_front();
                    px_valid <= 1'b1;
                    px_red   <= nxt.red;
                    px_green <= nxt.green;
                    px_blue  <= nxt.blue;
                end else begin
                    px_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!rst_n) begin
            ycc_ready <= 1'b0;
        end else begin
            if (ycc_valid && ycc_ready) begin
                t_ycc exp_ycc;
                t_ycc got_ycc;
                got_ycc = '{ycc_luma_first, ycc_luma_second, ycc_chroma_blue, ycc_chroma_red};
                beats_out++;
                if (ycc_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat %h", $time, got_ycc);
                end else begin
                    exp_ycc = ycc_q.pop_front();
                    if (got_ycc.luma_first !== exp_ycc.luma_first) begin
                        mismatches++;
                        $display("%0t: luma_first expected %h got %h", $time,
                                 exp_ycc.luma_first, got_ycc.luma_first);
                    end
                    if (got_ycc.luma_second !== exp_ycc.luma_second) begin
                        mismatches++;
                        $display("%0t: luma_second expected %h got %h", $time,
                                 exp_ycc.luma_second, got_ycc.luma_second);
                    end
                    if (got_ycc.chroma_blue !== exp_ycc.chroma_blue) begin
                        mismatches++;
                        $display("%0t: chroma_blue expected %h got %h", $time,
                                 exp_ycc.chroma_blue, got_ycc.chroma_blue);
                    end
                    if (got_ycc.chroma_red !== exp_ycc.chroma_red) begin
                        mismatches++;
                        $display("%0t: chroma_red expected %h got %h", $time,
                                 exp_ycc.chroma_red, got_ycc.chroma_red);
                    end
                end
            end
            ycc_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, ycc_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int n_px;
        int flavour;

        // Reset held low from the start, then released at an edge
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender lightly idle, receiver mostly stalled
        tx_idle_pct = 16;
        rx_idle_pct = 78;

        // Primaries, black, white and one mixed colour in full 4:4:4
        write_reg(REG_COLORIMETRY, COL_BT2020);
        write_reg(REG_SAMPLING_MODE, CFG_DATA_W'(MODE_444));
        queue_pixel(8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'hFF, 8'h00, 8'h00);
        queue_pixel(8'h00, 8'hFF, 8'h00);
        queue_pixel(8'h00, 8'h00, 8'hFF);
        queue_pixel(8'h55, 8'hAA, 8'h0F);
        drain();

        // 4:2:2 pairs of opposing colours; the trailing green stays held
        write_reg(REG_SAMPLING_MODE, CFG_DATA_W'(MODE_422));
        queue_pixel(8'hFF, 8'h00, 8'h00);
        queue_pixel(8'h00, 8'hFF, 8'hFF);
        queue_pixel(8'h00, 8'h00, 8'hFF);
        queue_pixel(8'hFF, 8'hFF, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h00, 8'h00, 8'h00);
        queue_pixel(8'h00, 8'hFF, 8'h00);
        drain();

        // Change colorimetry mid-pair: the held pixel converts with the new weights
        write_reg(REG_COLORIMETRY, COL_DCIP3);
        queue_pixel(8'hFF, 8'h00, 8'hFF);
        queue_pixel(8'h80, 8'h80, 8'h80);
        drain();

        // Rewriting the mode drops the held grey without a result
        write_reg(REG_SAMPLING_MODE, CFG_DATA_W'(MODE_422));
        queue_pixel(8'h10, 8'h20, 8'h30);
        queue_pixel(8'hF0, 8'hE0, 8'hD0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        drain();

        // Drop the held white by switching to 4:4:4, upper data bit set
        write_reg(REG_COLORIMETRY, COL_BT2100);
        write_reg(REG_SAMPLING_MODE, {1'b1, MODE_444});
        queue_pixel(8'h00, 8'hFF, 8'h00);
        queue_pixel(8'h01, 8'hFE, 8'h7F);
        drain();

        // Random phases, each under its own setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == RAND_PHASES / 3) begin
                tx_idle_pct = 78;
                rx_idle_pct = 16;
            end else if (p == 2 * RAND_PHASES / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Every third phase keeps the mode, so an odd pixel may stay held
            // across a colorimetry change
            if (p % 3 != 2) begin
                write_reg(REG_SAMPLING_MODE, CFG_DATA_W'($urandom_range(1)));
            end
            write_reg(REG_COLORIMETRY, t_colorimetry'(p % 4));
            n_px = $urandom_range(135, 90);
            for (int k = 0; k < n_px; k++) begin
                flavour = $urandom_range(9);
                queue_pixel(random_channel(flavour), random_channel(flavour),
                            random_channel(flavour));
            end
            drain();
        end

        $display("Converted %0d pixels into %0d checked YCbCr beats.", pixels_in, beats_out);
        $display("Both sampling modes, all four colorimetry codes, mid-pair changes and drops.");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d field mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> rgb_to_ycbcr_converter.f
rtl/core/rgbyc_pkg.sv
rtl/core/rgbyc_input_stage.sv
rtl/core/rgbyc_pixel_terms.sv
rtl/core/rgbyc_output_stage.sv
rtl/core/rgb_to_ycbcr_converter.sv
rtl/core/rgbyc_checker.sv
test/rgb_to_ycbcr_converter_test.sv
